/* sv/sha1md_pkg.sv */
// ----------------------------------------------------------------------------
// sha1md_pkg
// shared types and constants of the sha-1 message digest block
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned IndexW = 3;
  localparam int unsigned NumH   = 5;

  typedef logic [WordW-1:0] word_t;

  // one queued input transaction; items with neither byte nor last are dropped
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  localparam word_t InitH0 = 32'h67452301;
  localparam word_t InitH1 = 32'hEFCDAB89;
  localparam word_t InitH2 = 32'h98BADCFE;
  localparam word_t InitH3 = 32'h10325476;
  localparam word_t InitH4 = 32'hC3D2E1F0;

  localparam word_t RoundK0 = 32'h5A827999;
  localparam word_t RoundK1 = 32'h6ED9EBA1;
  localparam word_t RoundK2 = 32'h8F1BBCDC;
  localparam word_t RoundK3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t init_hash(input logic [IndexW-1:0] idx);
    word_t v;
    case (idx)
      3'd0:    v = InitH0;
      3'd1:    v = InitH1;
      3'd2:    v = InitH2;
      3'd3:    v = InitH3;
      default: v = InitH4;
    endcase
    return v;
  endfunction

endpackage

/* sv/sha1md_fifo.sv */
// ----------------------------------------------------------------------------
// sha1md_fifo
// short queue between the input front and the compression engine
// ----------------------------------------------------------------------------
module sha1md_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sha1md_pkg::item_t  push_data_i,
  output logic               full_o,
  output logic               pop_valid_o,
  output sha1md_pkg::item_t  pop_data_o,
  input  logic               pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha1md_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // fill level never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue fill level above depth");

  // the front only pushes when there is room
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");

  // a lone push raises the fill level by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill level not tracking push");

endmodule

/* sv/sha1md_engine.sv */
// ----------------------------------------------------------------------------
// sha1md_engine
// byte packing, padding, 80-round compression and digest output
// ----------------------------------------------------------------------------
module sha1md_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  sha1md_pkg::item_t                    q_data_i,
  output logic                                 q_ready_o,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output sha1md_pkg::word_t                    m_word_o,
  output logic [sha1md_pkg::IndexW-1:0]        m_index_o,
  output logic                                 m_last_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_HADD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [sha1md_pkg::IndexW-1:0] LastWord = 3'd4;

  state_e                  state_q, state_d;
  sha1md_pkg::word_t       hash_q [sha1md_pkg::NumH];
  sha1md_pkg::word_t       hash_d [sha1md_pkg::NumH];
  sha1md_pkg::word_t       work_q [sha1md_pkg::NumH];
  sha1md_pkg::word_t       work_d [sha1md_pkg::NumH];
  sha1md_pkg::word_t       sched_q [16];
  logic [23:0]             acc_q, acc_d;
  logic [5:0]              cnt_q, cnt_d;
  logic [63:0]             bitlen_q, bitlen_d;
  logic [63:0]             len_sh_q, len_sh_d;
  logic [6:0]              rnd_q, rnd_d;
  logic                    pad_act_q, pad_act_d;
  logic                    pad_80_q, pad_80_d;
  logic                    pad_len_q, pad_len_d;
  logic                    pad_fin_q, pad_fin_d;
  logic [sha1md_pkg::IndexW-1:0] emit_idx_q, emit_idx_d;

  logic                    m_valid_q, m_valid_d;
  sha1md_pkg::word_t       m_word_q;
  logic [sha1md_pkg::IndexW-1:0] m_index_q;
  logic                    m_last_q;
  logic                    out_load;

  logic                    absorb_en;
  logic [7:0]              absorb_byte;
  logic                    sched_push;
  sha1md_pkg::word_t       sched_word;

  sha1md_pkg::word_t       rb, rc, rd, rf, rk, rw, rexp, rtmp;

  // round datapath
  always_comb begin
    rb = work_q[1];
    rc = work_q[2];
    rd = work_q[3];
    rw = sched_q[0];
    rexp = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
    rexp = {rexp[30:0], rexp[31]};
    if (rnd_q < 7'd20) begin
      rf = (rb & rc) | (~rb & rd);
      rk = sha1md_pkg::RoundK0;
    end else if (rnd_q < 7'd40) begin
      rf = rb ^ rc ^ rd;
      rk = sha1md_pkg::RoundK1;
    end else if (rnd_q < 7'd60) begin
      rf = (rb & rc) | (rb & rd) | (rc & rd);
      rk = sha1md_pkg::RoundK2;
    end else begin
      rf = rb ^ rc ^ rd;
      rk = sha1md_pkg::RoundK3;
    end
    rtmp = {work_q[0][26:0], work_q[0][31:27]} + rf + work_q[4] + rw + rk;
  end

  always_comb begin
    state_d    = state_q;
    hash_d     = hash_q;
    work_d     = work_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    bitlen_d   = bitlen_q;
    len_sh_d   = len_sh_q;
    rnd_d      = rnd_q;
    pad_act_d  = pad_act_q;
    pad_80_d   = pad_80_q;
    pad_len_d  = pad_len_q;
    pad_fin_d  = pad_fin_q;
    emit_idx_d = emit_idx_q;
    q_ready_o  = 1'b0;
    out_load   = 1'b0;
    absorb_en  = 1'b0;
    absorb_byte = '0;
    sched_push = 1'b0;
    sched_word = '0;

    case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (q_data_i.has_byte) begin
            absorb_en   = 1'b1;
            absorb_byte = q_data_i.data_byte;
            bitlen_d    = bitlen_q + 64'd8;
          end
          if (q_data_i.last) begin
            pad_act_d = 1'b1;
            pad_80_d  = 1'b1;
            pad_len_d = 1'b0;
            pad_fin_d = 1'b0;
            len_sh_d  = q_data_i.has_byte ? bitlen_q + 64'd8 : bitlen_q;
            bitlen_d  = '0;
          end
          if (q_data_i.has_byte && cnt_q == LastByte) begin
            work_d  = hash_q;
            rnd_d   = '0;
            state_d = ST_ROUND;
          end else if (q_data_i.last) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        absorb_en = 1'b1;
        if (pad_80_q) begin
          absorb_byte = sha1md_pkg::PadByte;
          pad_80_d    = 1'b0;
        end else if (!pad_len_q && cnt_q != LenStart) begin
          absorb_byte = '0;
        end else begin
          absorb_byte = len_sh_q[63:56];
          len_sh_d    = {len_sh_q[55:0], 8'h00};
          pad_len_d   = 1'b1;
          if (cnt_q == LastByte) begin
            pad_fin_d = 1'b1;
          end
        end
        if (cnt_q == LastByte) begin
          work_d  = hash_q;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        sched_push = 1'b1;
        sched_word = rexp;
        work_d[4]  = work_q[3];
        work_d[3]  = work_q[2];
        work_d[2]  = {work_q[1][1:0], work_q[1][31:2]};
        work_d[1]  = work_q[0];
        work_d[0]  = rtmp;
        if (rnd_q == LastRound) begin
          rnd_d   = '0;
          state_d = ST_HADD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      ST_HADD: begin
        for (int i = 0; i < sha1md_pkg::NumH; i++) begin
          hash_d[i] = hash_q[i] + work_q[i];
        end
        if (pad_fin_q) begin
          emit_idx_d = '0;
          state_d    = ST_EMIT;
        end else if (pad_act_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_ready_i) begin
          out_load = 1'b1;
          if (emit_idx_q == LastWord) begin
            for (int i = 0; i < sha1md_pkg::NumH; i++) begin
              hash_d[i] = sha1md_pkg::init_hash(sha1md_pkg::IndexW'(i));
            end
            pad_act_d = 1'b0;
            pad_fin_d = 1'b0;
            pad_len_d = 1'b0;
            state_d   = ST_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // big-endian packing: four bytes form one schedule word
    if (absorb_en) begin
      acc_d = {acc_q[15:0], absorb_byte};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q[1:0] == 2'd3) begin
        sched_push = 1'b1;
        sched_word = {acc_q, absorb_byte};
      end
    end

    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      for (int i = 0; i < sha1md_pkg::NumH; i++) begin
        hash_q[i] <= sha1md_pkg::init_hash(sha1md_pkg::IndexW'(i));
        work_q[i] <= '0;
      end
      cnt_q      <= '0;
      bitlen_q   <= '0;
      rnd_q      <= '0;
      pad_act_q  <= 1'b0;
      pad_80_q   <= 1'b0;
      pad_len_q  <= 1'b0;
      pad_fin_q  <= 1'b0;
      emit_idx_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      hash_q     <= hash_d;
      work_q     <= work_d;
      cnt_q      <= cnt_d;
      bitlen_q   <= bitlen_d;
      rnd_q      <= rnd_d;
      pad_act_q  <= pad_act_d;
      pad_80_q   <= pad_80_d;
      pad_len_q  <= pad_len_d;
      pad_fin_q  <= pad_fin_d;
      emit_idx_q <= emit_idx_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // payload registers: byte accumulator, length shifter, schedule line, output
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    len_sh_q <= len_sh_d;
    if (sched_push) begin
      for (int i = 0; i < 15; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[15] <= sched_word;
    end
    if (out_load) begin
      m_word_q  <= hash_q[emit_idx_q];
      m_index_q <= emit_idx_q;
      m_last_q  <= (emit_idx_q == LastWord);
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_word_o  = m_word_q;
  assign m_index_o = m_index_q;
  assign m_last_o  = m_last_q;

  // round counter only runs during compression
  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ROUND) |-> rnd_q == '0) else $error("round counter left running");

  // digest goes out only on a block boundary
  a_emit_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> cnt_q == '0) else $error("digest with partial block");

  // last digest word always carries the top index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_last_q) |-> m_index_q == LastWord) else $error("last flag on wrong word");

  // queue is drained only while waiting for input
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && q_ready_o) |-> state_q == ST_IDLE) else $error("pop outside idle");

endmodule

/* sv/sha1_message_digest_top.sv */
// ----------------------------------------------------------------------------
// sha1_message_digest_top
// streaming sha-1: message bytes in, five digest words out per message
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata           | tuser          | tlast
//  ----------+-----+-----------------+----------------+---------------
//  s_axis    | in  | [7:0] data_byte | has_byte       | last
//  m_axis    | out | [31:0] digest   | [2:0] word_idx | digest_last
//
//  - message bytes are packed into big-endian words as they are taken; every
//    64th byte starts a compression of 80 rounds (one round per cycle) and a
//    fold of the working words into the hash
//  - a transaction with tlast adds 9 to 72 padding bytes and one or two
//    more compressions, then five digest transactions, one per cycle when
//    the output is not stalled
//  - reset is asynchronous, active low; the engine starts at the initial
//    hash values with an empty block
//  - input transactions collect in a short queue while the engine is busy;
//    the output holds a registered word so a stalled sink never loses data
//
module sha1_message_digest_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // message input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,
  // digest output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o
);

  sha1md_pkg::item_t in_item;
  sha1md_pkg::item_t q_item;
  logic              q_full;
  logic              q_push;
  logic              q_valid;
  logic              q_ready;

  // front: transactions without a byte and without last change nothing,
  // so they are accepted and dropped here
  assign in_item.data_byte = s_axis_tdata_i;
  assign in_item.has_byte  = s_axis_tuser_i;
  assign in_item.last      = s_axis_tlast_i;

  assign s_axis_tready_o = !q_full;
  assign q_push = s_axis_tvalid_i && !q_full && (s_axis_tuser_i || s_axis_tlast_i);

  sha1md_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (in_item),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_item),
    .pop_ready_i (q_ready)
  );

  // back: packing, padding, rounds and the output register
  sha1md_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_item),
    .q_ready_o (q_ready),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_word_o  (m_axis_tdata_o),
    .m_index_o (m_axis_tuser_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

/* test/sha1_digest_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_digest_checker
// watches both stream channels of the sha-1 digest block, keeps its own
// sha-1 state to predict the five digest words of each message, and compares
// every output transaction with the oldest predicted word
// ----------------------------------------------------------------------------
module sha1_digest_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [7:0]        s_axis_tdata_i,
  input  logic              s_axis_tuser_i,
  input  logic              s_axis_tlast_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [31:0]       m_axis_tdata_i,
  input  logic [2:0]        m_axis_tuser_i,
  input  logic              m_axis_tlast_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_count_o
);

  typedef struct packed {
    sha1md_pkg::word_t                 word;
    logic [sha1md_pkg::IndexW-1:0]     word_idx;
    logic                              last_flag;
  } digest_word_t;

  digest_word_t expected_digest_q[$];

  sha1md_pkg::word_t hash_q [sha1md_pkg::NumH];
  sha1md_pkg::word_t block_words [16];
  logic [5:0]        fill_count;
  logic [63:0]       bit_len;

  task automatic restart_message();
    hash_q[0]  = sha1md_pkg::InitH0;
    hash_q[1]  = sha1md_pkg::InitH1;
    hash_q[2]  = sha1md_pkg::InitH2;
    hash_q[3]  = sha1md_pkg::InitH3;
    hash_q[4]  = sha1md_pkg::InitH4;
    fill_count = '0;
    bit_len    = '0;
  endtask

  task automatic compress_block();
    sha1md_pkg::word_t a, b, c, d, e, f, k, w, t;
    sha1md_pkg::word_t sched [16];
    int unsigned       r;
    for (r = 0; r < 16; r++) sched[r] = block_words[r];
    a = hash_q[0];
    b = hash_q[1];
    c = hash_q[2];
    d = hash_q[3];
    e = hash_q[4];
    for (r = 0; r < 80; r++) begin
      // rolling schedule: the window slot is replaced by the new word
      if (r >= 16) begin
        w = sched[(r - 3) % 16] ^ sched[(r - 8) % 16] ^ sched[(r - 14) % 16] ^ sched[r % 16];
        sched[r % 16] = {w[30:0], w[31]};
      end
      w = sched[r % 16];
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1md_pkg::RoundK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::RoundK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1md_pkg::RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::RoundK3;
      end
      t = {a[26:0], a[31:27]} + f + e + w + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_q[0] = hash_q[0] + a;
    hash_q[1] = hash_q[1] + b;
    hash_q[2] = hash_q[2] + c;
    hash_q[3] = hash_q[3] + d;
    hash_q[4] = hash_q[4] + e;
  endtask

  // big-endian packing, a full block is compressed at once
  task automatic absorb_byte(input logic [7:0] value);
    sha1md_pkg::word_t placed;
    placed = {value, 24'h0} >> (8 * fill_count[1:0]);
    if (fill_count[1:0] == 2'd0) begin
      block_words[fill_count[5:2]] = placed;
    end else begin
      block_words[fill_count[5:2]] = block_words[fill_count[5:2]] | placed;
    end
    fill_count = fill_count + 6'd1;
    if (fill_count == 6'd0) compress_block();
  endtask

  task automatic predict_digest(input logic [7:0] value, input logic has_byte,
                                input logic msg_end);
    logic [63:0]  len;
    int unsigned  i;
    digest_word_t entry;
    if (has_byte) begin
      absorb_byte(value);
      bit_len = bit_len + 64'd8;
    end
    if (msg_end) begin
      len = bit_len;
      absorb_byte(sha1md_pkg::PadByte);
      while (fill_count != 6'd56) absorb_byte(8'h00);
      for (i = 0; i < 8; i++) absorb_byte(len[63 - 8 * i -: 8]);
      for (i = 0; i < sha1md_pkg::NumH; i++) begin
        entry.word      = hash_q[i];
        entry.word_idx  = sha1md_pkg::IndexW'(i);
        entry.last_flag = (i == sha1md_pkg::NumH - 1);
        expected_digest_q.push_back(entry);
      end
      restart_message();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    digest_word_t want;
    if (!rst_ni) begin
      restart_message();
      expected_digest_q.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_digest(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_digest_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%t unexpected digest transaction: word %h idx %0d last %0b",
                     $realtime, m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
          end
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_digest_q.pop_front();
          if (m_axis_tdata_i !== want.word || m_axis_tuser_i !== want.word_idx ||
              m_axis_tlast_i !== want.last_flag) begin
            if (fail_count_o < 10) begin
              $display("%t digest mismatch: expected word %h idx %0d last %0b, got %h %0d %0b",
                       $realtime, want.word, want.word_idx, want.last_flag,
                       m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
            end
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      pending_count_o = expected_digest_q.size();
    end
  end

endmodule

/* test/tb_sha1_message_digest_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest_top
// drives byte-wise messages into the sha-1 digest block with random gaps and
// output stalls; a checker beside the block predicts and compares the digests
// ----------------------------------------------------------------------------
module tb_sha1_message_digest_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  // message channel
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;   // [0] has_byte
  logic        s_axis_tlast = 1'b0;

  // digest channel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [31:0] digest_word
  logic [2:0]  m_axis_tuser;          // [2:0] word_index
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned sent_items;            // accepted input transactions

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  sha1_message_digest_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  sha1_digest_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 8) return 0;
    else if (roll < 18) return $urandom_range(1, 3);
    else return $urandom_range(10, 40);
  endfunction

  // one input transaction; returns at the edge where it was taken, or after the gap that follows
  task automatic send_item(input logic [7:0] value, input logic has_byte,
                           input logic msg_end, input int unsigned gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= msg_end;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
    // valid stays high into the next transaction when there is no gap
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every predicted digest word has come out;
  // the checker count is read at the falling edge, away from its update
  task automatic wait_digests_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    @(posedge clk_i);
  endtask

  // a whole message of random bytes, sprinkled with items that carry nothing;
  // the last byte either carries tlast itself or an empty item ends the message
  task automatic send_message(input int unsigned len, input bit byte_ends_msg,
                              input bit bursty);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0, bursty ? 0 : idle_gap());
      end
      send_item(8'($urandom), 1'b1, (i == len - 1) && byte_ends_msg,
                bursty ? 0 : idle_gap());
    end
    if (len == 0 || !byte_ends_msg) begin
      send_item(8'($urandom), 1'b0, 1'b1, bursty ? 0 : idle_gap());
    end
  endtask

  // sink: ready stretches, some of them long, broken by stalls
  initial begin : sink_side
    int unsigned run_len;
    int unsigned gap;
    @(posedge clk_i);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      gap = idle_gap();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned msg_len;
    sent_items = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message straight after reset
    send_item(8'h00, 1'b0, 1'b1, idle_gap());
    // an item with nothing in it must leave the state alone
    send_item(8'hFF, 1'b0, 1'b0, idle_gap());
    send_item(8'hA5, 1'b0, 1'b1, 0);
    // "abc", last flag on the final byte
    send_item(8'h61, 1'b1, 1'b0, 0);
    send_item(8'h62, 1'b1, 1'b0, 0);
    send_item(8'h63, 1'b1, 1'b1, idle_gap());
    // field extremes, closed by an item with no byte
    send_item(8'h00, 1'b1, 1'b0, idle_gap());
    send_item(8'hFF, 1'b1, 1'b0, idle_gap());
    send_item(8'h5A, 1'b0, 1'b1, idle_gap());
    // single byte equal to the pad value, then a lone 0xff
    send_item(8'h80, 1'b1, 1'b1, 0);
    send_item(8'hFF, 1'b1, 1'b1, idle_gap());
    wait_digests_drained();

    // random messages; lengths around one and two blocks hit the cases
    // where the padding spills into an extra block
    while (sent_items < 200) begin
      case ($urandom_range(0, 11))
        0, 1:    msg_len = $urandom_range(54, 66);
        2:       msg_len = $urandom_range(117, 129);
        default: msg_len = $urandom_range(0, 12);
      endcase
      // keep the whole run near its item budget
      if (msg_len > 210 - sent_items) msg_len = 210 - sent_items;
      send_message(msg_len, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) wait_digests_drained();
    end

    // let the block settle so any stray output would still be caught
    wait_digests_drained();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_sha1_message_digest_top passed");
    end else begin
      $display("tb_sha1_message_digest_top failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("tb_sha1_message_digest_top failed");
    $finish;
  end

endmodule
